// ===== hw/rtl/fsd_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fsd_pkg: shared types, constants and arithmetic helpers
// Fixed-point widths, register indexes and the saturate/weight helpers used
// by the error-diffusion datapath.
// ============================================================================
package fsd_pkg;

	localparam int MAX_WIDTH    = 1024;
	localparam int MAX_HEIGHT   = 1024;
	localparam int FRAC_BITS    = 8;
	localparam int ERR_BITS     = 10 + FRAC_BITS;
	localparam int ACC_W        = ERR_BITS + 2;
	localparam int PROD_W       = ERR_BITS + 4;
	localparam int PIX_W        = 8;
	localparam int CFG_W        = 11;
	localparam int CFG_IDX_W    = 1;
	localparam int COL_W        = $clog2(MAX_WIDTH);
	localparam int ROW_W        = $clog2(MAX_HEIGHT);
	localparam int FILL_W       = COL_W + 1;
	localparam int BANK_AW      = COL_W - 1;
	localparam int WIDTH_RESET  = 512;
	localparam int HEIGHT_RESET = 512;

	localparam int ERR_MAX      = (1 << (ERR_BITS - 1)) - 1;
	localparam int THRESH       = 255 << (FRAC_BITS - 1);
	localparam int FULL_SCALE   = 255 << FRAC_BITS;
	localparam int WEIGHT_SHIFT = 4;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

	localparam logic [3:0] W_RIGHT       = 4'd7;
	localparam logic [3:0] W_BELOW_LEFT  = 4'd3;
	localparam logic [3:0] W_BELOW       = 4'd5;
	localparam logic [3:0] W_BELOW_RIGHT = 4'd1;

	localparam logic [PIX_W-1:0] PIX_MAX = '1;

	typedef logic signed [ERR_BITS-1:0] err_t;
	typedef logic signed [ACC_W-1:0]    acc_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic [COL_W-1:0]           col_t;
	typedef logic [PIX_W-1:0]           pix_t;

	typedef struct packed {
		col_t col;
		logic last_col;
		logic last_row;
	} pos_t;

	typedef struct packed {
		pix_t pix;
		pos_t pos;
	} item_t;

	typedef struct packed {
		logic a_en;
		col_t a_addr;
		err_t a_data;
		logic b_en;
		col_t b_addr;
		err_t b_data;
	} wr_t;

	typedef struct packed {
		pix_t pixel;
		logic last;
	} res_t;

	function automatic err_t sat(acc_t v);
		err_t r;
		if (v > acc_t'(ERR_MAX)) begin
			r = err_t'(ERR_MAX);
		end else if (v < acc_t'(-ERR_MAX)) begin
			r = err_t'(-ERR_MAX);
		end else begin
			r = err_t'(v);
		end
		return r;
	endfunction

	// floor(e * k / 16)
	function automatic err_t share(err_t e, logic [3:0] k);
		prod_t p;
		p = prod_t'(e) * prod_t'(k);
		return err_t'(p >>> WEIGHT_SHIFT);
	endfunction

endpackage

// ===== hw/rtl/fsd_ifs.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fsd channels: grayscale input and dithered output streams
// Valid/ready channels; a word moves at a clock edge with valid and ready high.
// ============================================================================
interface fsd_gray_if;
	logic                      valid;
	logic                      ready;
	logic [fsd_pkg::PIX_W-1:0] gray_pixel;

	modport source(output valid, output gray_pixel, input ready);
	modport sink(input valid, input gray_pixel, output ready);
endinterface

interface fsd_dither_if;
	logic                      valid;
	logic                      ready;
	logic [fsd_pkg::PIX_W-1:0] dithered_pixel;
	logic                      frame_last;

	modport source(output valid, output dithered_pixel, output frame_last, input ready);
	modport sink(input valid, input dithered_pixel, input frame_last, output ready);
endinterface

// ===== hw/rtl/fsd_ram.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fsd_ram: simple dual-port RAM
// One write port, one read port, registered read data, no reset.
// ============================================================================
module fsd_ram #(
	parameter int ADDR_W = 9,
	parameter int DATA_W = 18
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/fsd_pos.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fsd_pos: image size registers and raster position counters
// Clamps the size registers and the counters, flags row and frame ends.
// ============================================================================
module fsd_pos (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fsd_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [fsd_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           advance,
	output fsd_pkg::pos_t                  pos
);

	logic [fsd_pkg::CFG_W-1:0] width_q;
	logic [fsd_pkg::CFG_W-1:0] height_q;
	fsd_pkg::col_t             col_q;
	logic [fsd_pkg::ROW_W-1:0] row_q;
	fsd_pkg::col_t             col_lim;
	logic [fsd_pkg::ROW_W-1:0] row_lim;
	fsd_pkg::col_t             col;
	logic [fsd_pkg::ROW_W-1:0] row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= fsd_pkg::CFG_W'(fsd_pkg::WIDTH_RESET);
			height_q <= fsd_pkg::CFG_W'(fsd_pkg::HEIGHT_RESET);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				fsd_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				fsd_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// last valid column and row after clamping the size to 1..max
	always_comb begin
		if (width_q == '0) begin
			col_lim = '0;
		end else if (width_q > fsd_pkg::CFG_W'(fsd_pkg::MAX_WIDTH)) begin
			col_lim = fsd_pkg::COL_W'(fsd_pkg::MAX_WIDTH - 1);
		end else begin
			col_lim = fsd_pkg::COL_W'(width_q - 1'b1);
		end
		if (height_q == '0) begin
			row_lim = '0;
		end else if (height_q > fsd_pkg::CFG_W'(fsd_pkg::MAX_HEIGHT)) begin
			row_lim = fsd_pkg::ROW_W'(fsd_pkg::MAX_HEIGHT - 1);
		end else begin
			row_lim = fsd_pkg::ROW_W'(height_q - 1'b1);
		end
		col          = (col_q > col_lim) ? col_lim : col_q;
		row          = (row_q > row_lim) ? row_lim : row_q;
		pos.col      = col;
		pos.last_col = (col == col_lim);
		pos.last_row = (row == row_lim);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (pos.last_col) begin
				col_q <= '0;
				row_q <= pos.last_row ? '0 : row + 1'b1;
			end else begin
				col_q <= col + 1'b1;
				row_q <= row;
			end
		end
	end

endmodule

// ===== hw/rtl/fsd_diffuse.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fsd_diffuse: threshold and error spreading for one pixel
// Adds the carried errors, quantizes, splits the error into the four shares
// and forms the two line-buffer writes.
// ============================================================================
module fsd_diffuse (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  fsd_pkg::item_t item,
	input  fsd_pkg::err_t  below_err,
	output fsd_pkg::wr_t   wr,
	output fsd_pkg::res_t  res
);

	fsd_pkg::err_t rc_q;
	fsd_pkg::err_t pend_q;
	fsd_pkg::err_t brp_q;

	fsd_pkg::acc_t acc;
	fsd_pkg::err_t val;
	fsd_pkg::err_t err;
	fsd_pkg::err_t s_right;
	fsd_pkg::err_t s_bl;
	fsd_pkg::err_t s_below;
	fsd_pkg::err_t s_br;
	fsd_pkg::err_t new_pend;
	logic          above;
	logic          keep_row;

	always_comb begin
		acc = fsd_pkg::acc_t'({item.pix, {fsd_pkg::FRAC_BITS{1'b0}}})
			+ fsd_pkg::acc_t'(rc_q) + fsd_pkg::acc_t'(below_err);
		val   = fsd_pkg::sat(acc);
		above = (val > fsd_pkg::err_t'(fsd_pkg::THRESH));
		err   = above ? fsd_pkg::sat(fsd_pkg::acc_t'(val) - fsd_pkg::acc_t'(fsd_pkg::FULL_SCALE))
			: val;

		s_right = fsd_pkg::share(err, fsd_pkg::W_RIGHT);
		s_bl    = fsd_pkg::share(err, fsd_pkg::W_BELOW_LEFT);
		s_below = fsd_pkg::share(err, fsd_pkg::W_BELOW);
		s_br    = fsd_pkg::share(err, fsd_pkg::W_BELOW_RIGHT);

		new_pend = fsd_pkg::sat(fsd_pkg::acc_t'(brp_q) + fsd_pkg::acc_t'(s_below));
		keep_row = !item.pos.last_row && !item.pos.last_col;

		// outside the last row the slot to the left gets its final sum; the current
		// slot is zeroed or, at row end, takes its pending below sum directly
		wr.a_en   = !item.pos.last_row && (item.pos.col != '0);
		wr.a_addr = item.pos.col - 1'b1;
		wr.a_data = fsd_pkg::sat(fsd_pkg::acc_t'(pend_q) + fsd_pkg::acc_t'(s_bl));
		wr.b_en   = 1'b1;
		wr.b_addr = item.pos.col;
		wr.b_data = (!item.pos.last_row && item.pos.last_col) ? new_pend : '0;

		res.pixel = above ? fsd_pkg::PIX_MAX : '0;
		res.last  = item.pos.last_col && item.pos.last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_q   <= '0;
			pend_q <= '0;
			brp_q  <= '0;
		end else if (fire) begin
			rc_q   <= item.pos.last_col ? '0 : s_right;
			pend_q <= keep_row ? new_pend : '0;
			brp_q  <= keep_row ? s_br : '0;
		end
	end

endmodule

// ===== hw/rtl/floyd_steinberg_dither.sv =====
`timescale 1ns / 1ps
// ============================================================================
// floyd_steinberg_dither: streaming error-diffusion dither
// Turns 8-bit grayscale pixels in raster order into 0/255 pixels.
// ============================================================================
// Usage:
//   gray_ch carries one grayscale pixel per word in raster order; dither_ch
//   returns one word per pixel, 0 or 255, with frame_last set on the last
//   pixel of each frame. image_width and image_height (index 0 and 1 on the
//   write port) set the frame size; write them only while the block is idle.
//   Throughput is one pixel per clock while dither_ch is ready. An accepted
//   word is held in the read stage during the line-buffer read, then goes
//   through the add/threshold/diffuse loop on the carried errors into the
//   output register. The next-row errors live in two RAM banks (even and
//   odd columns) so the two writes each pixel makes land in the same cycle;
//   a same-cycle read of a slot being written is forwarded.
//   Reset sets both sizes to 512 and starts a new frame. The error buffer
//   needs no clearing pass: a fill count marks the slots written in the
//   current frame and all others read as zero, so it restarts at once at
//   every frame end.
//   When the receiver stalls, one result waits in the output register and
//   one pixel in the read stage; gray_ch.ready drops only when both are full.
// ============================================================================
module floyd_steinberg_dither (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [fsd_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [fsd_pkg::CFG_W-1:0]     cfg_data,
	fsd_gray_if.sink                      gray_ch,
	fsd_dither_if.source                  dither_ch
);

	fsd_pkg::pos_t             pos;
	logic                      accept;
	logic                      s1_fire;
	logic                      s1_valid_q;
	fsd_pkg::item_t            item_s1;
	logic                      fwd_hit_s1;
	fsd_pkg::err_t             fwd_data_s1;
	logic [fsd_pkg::FILL_W-1:0] fill_q;
	logic [fsd_pkg::FILL_W-1:0] col_next;

	fsd_pkg::wr_t              wr;
	fsd_pkg::res_t             res;
	fsd_pkg::err_t             below_err;
	fsd_pkg::err_t             mem_err;
	logic                      hit_b;
	logic                      hit_a;
	logic                      b_even;

	logic                      even_we;
	logic                      odd_we;
	logic [fsd_pkg::BANK_AW-1:0] even_waddr;
	logic [fsd_pkg::BANK_AW-1:0] odd_waddr;
	fsd_pkg::err_t             even_wdata;
	fsd_pkg::err_t             odd_wdata;
	fsd_pkg::err_t             even_rdata;
	fsd_pkg::err_t             odd_rdata;

	logic                      out_valid_q;
	fsd_pkg::res_t             out_q;

	assign s1_fire       = s1_valid_q && (!out_valid_q || dither_ch.ready);
	assign gray_ch.ready = !s1_valid_q || s1_fire;
	assign accept        = gray_ch.valid && gray_ch.ready;

	fsd_pos u_pos (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.advance  (accept),
		.pos      (pos)
	);

	// even/odd column banks, both read at the same row address
	fsd_ram #(
		.ADDR_W (fsd_pkg::BANK_AW),
		.DATA_W (fsd_pkg::ERR_BITS)
	) u_ram_even (
		.clk   (clk),
		.we    (even_we),
		.waddr (even_waddr),
		.wdata (even_wdata),
		.re    (accept),
		.raddr (pos.col[fsd_pkg::COL_W-1:1]),
		.rdata (even_rdata)
	);

	fsd_ram #(
		.ADDR_W (fsd_pkg::BANK_AW),
		.DATA_W (fsd_pkg::ERR_BITS)
	) u_ram_odd (
		.clk   (clk),
		.we    (odd_we),
		.waddr (odd_waddr),
		.wdata (odd_wdata),
		.re    (accept),
		.raddr (pos.col[fsd_pkg::COL_W-1:1]),
		.rdata (odd_rdata)
	);

	// the two writes of one pixel always hit different banks
	always_comb begin
		b_even     = !wr.b_addr[0];
		even_we    = s1_fire && (b_even ? wr.b_en : wr.a_en);
		odd_we     = s1_fire && (b_even ? wr.a_en : wr.b_en);
		even_waddr = b_even ? wr.b_addr[fsd_pkg::COL_W-1:1] : wr.a_addr[fsd_pkg::COL_W-1:1];
		odd_waddr  = b_even ? wr.a_addr[fsd_pkg::COL_W-1:1] : wr.b_addr[fsd_pkg::COL_W-1:1];
		even_wdata = b_even ? wr.b_data : wr.a_data;
		odd_wdata  = b_even ? wr.a_data : wr.b_data;
	end

	// forward a write that lands in the same cycle as the read
	assign hit_b = wr.b_en && (pos.col == wr.b_addr);
	assign hit_a = wr.a_en && (pos.col == wr.a_addr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (gray_ch.ready) begin
			s1_valid_q <= gray_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.pix <= gray_ch.gray_pixel;
			item_s1.pos <= pos;
			fwd_hit_s1  <= s1_fire && (hit_b || hit_a);
			fwd_data_s1 <= hit_b ? wr.b_data : wr.a_data;
		end
	end

	// slots at or past the fill count are untouched this frame: read zero
	always_comb begin
		mem_err = item_s1.pos.col[0] ? odd_rdata : even_rdata;
		if ({1'b0, item_s1.pos.col} >= fill_q) begin
			below_err = '0;
		end else if (fwd_hit_s1) begin
			below_err = fwd_data_s1;
		end else begin
			below_err = mem_err;
		end
	end

	fsd_diffuse u_diffuse (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (s1_fire),
		.item      (item_s1),
		.below_err (below_err),
		.wr        (wr),
		.res       (res)
	);

	assign col_next = {1'b0, item_s1.pos.col} + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (s1_fire) begin
			if (res.last) begin
				fill_q <= '0;
			end else if (col_next > fill_q) begin
				fill_q <= col_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire) begin
			out_valid_q <= 1'b1;
		end else if (dither_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			out_q <= res;
		end
	end

	assign dither_ch.valid          = out_valid_q;
	assign dither_ch.dithered_pixel = out_q.pixel;
	assign dither_ch.frame_last     = out_q.last;

endmodule

// ===== hw/rtl/fsd_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fsd_checker: port-level checks for the dither block
// Output hold, binary output, ready while drained, fixed fill latency.
// ============================================================================
module fsd_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [fsd_pkg::PIX_W-1:0] out_pixel,
	input logic                      out_last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_pixel) && $stable(out_last))
		else $error("output word changed while stalled");

	a_binary: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_pixel == '0 || out_pixel == fsd_pkg::PIX_MAX))
		else $error("output pixel not 0 or 255");

	a_ready_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##2 out_valid)
		else $error("accepted word produced no output two cycles later");

endmodule

bind floyd_steinberg_dither fsd_checker u_fsd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (gray_ch.valid),
	.in_ready  (gray_ch.ready),
	.out_valid (dither_ch.valid),
	.out_ready (dither_ch.ready),
	.out_pixel (dither_ch.dithered_pixel),
	.out_last  (dither_ch.frame_last)
);

// ===== tb/floyd_steinberg_dither_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// floyd_steinberg_dither_tb: self-checking bench for the error-diffusion dither
// Streams grayscale words through the block under random valid/ready gaps and
// compares every dithered word with a cycle-free prediction of the diffusion
// kept in a scoreboard class. Frame sizes change between runs of pixels,
// including out-of-range sizes and changes in the middle of a frame.
// ============================================================================

typedef enum int {TONE_UNIFORM, TONE_MID, TONE_EXTREME, TONE_FLAT} tone_t;

class halftone_scoreboard_t;
	logic [fsd_pkg::CFG_W-1:0] width_reg;
	logic [fsd_pkg::CFG_W-1:0] height_reg;
	fsd_pkg::err_t             below_err[fsd_pkg::MAX_WIDTH];
	fsd_pkg::err_t             carry_right;
	fsd_pkg::err_t             pend_below_left;
	fsd_pkg::err_t             part_below_right;
	int unsigned               col_pos;
	int unsigned               row_pos;
	fsd_pkg::res_t             halftone_q[$];
	int                        mismatches;
	int                        accepted;
	int                        checked;
	int                        frames;

	function new();
		width_reg        = fsd_pkg::CFG_W'(fsd_pkg::WIDTH_RESET);
		height_reg       = fsd_pkg::CFG_W'(fsd_pkg::HEIGHT_RESET);
		foreach (below_err[i]) below_err[i] = '0;
		carry_right      = '0;
		pend_below_left  = '0;
		part_below_right = '0;
		col_pos          = 0;
		row_pos          = 0;
		mismatches       = 0;
		accepted         = 0;
		checked          = 0;
		frames           = 0;
	endfunction

	function void set_register(logic [fsd_pkg::CFG_IDX_W-1:0] idx,
			logic [fsd_pkg::CFG_W-1:0] value);
		if (idx == fsd_pkg::REG_IMAGE_WIDTH) begin
			width_reg = value;
		end else if (idx == fsd_pkg::REG_IMAGE_HEIGHT) begin
			height_reg = value;
		end
	endfunction

	function int clip(longint v);
		if (v > fsd_pkg::ERR_MAX) return fsd_pkg::ERR_MAX;
		if (v < -fsd_pkg::ERR_MAX) return -fsd_pkg::ERR_MAX;
		return int'(v);
	endfunction

	// floor(e * k / 16)
	function int weigh(int e, logic [3:0] k);
		longint p;
		p = longint'(e) * longint'(k);
		return int'(p >>> fsd_pkg::WEIGHT_SHIFT);
	endfunction

	function int pending();
		return halftone_q.size();
	endfunction

	// Predict the word for one accepted gray pixel and advance the diffusion state.
	function void take_pixel(fsd_pkg::pix_t gray);
		int unsigned   w, h, c, r;
		bit            col_end, row_end;
		longint        sum;
		int            level, err;
		fsd_pkg::res_t word;
		w = width_reg;
		h = height_reg;
		if (w < 1) w = 1;
		if (w > fsd_pkg::MAX_WIDTH) w = fsd_pkg::MAX_WIDTH;
		if (h < 1) h = 1;
		if (h > fsd_pkg::MAX_HEIGHT) h = fsd_pkg::MAX_HEIGHT;
		c = col_pos;
		r = row_pos;
		// a count past a shrunken size counts as the last position
		if (c > w - 1) c = w - 1;
		if (r > h - 1) r = h - 1;
		col_end = (c == w - 1);
		row_end = (r == h - 1);

		sum = (longint'(gray) << fsd_pkg::FRAC_BITS) + longint'(carry_right)
			+ longint'(below_err[c]);
		level = clip(sum);
		if (level > fsd_pkg::THRESH) begin
			word.pixel = fsd_pkg::PIX_MAX;
			err = clip(longint'(level) - longint'(fsd_pkg::FULL_SCALE));
		end else begin
			word.pixel = '0;
			err = level;
		end

		carry_right = col_end ? fsd_pkg::err_t'(0)
			: fsd_pkg::err_t'(weigh(err, fsd_pkg::W_RIGHT));
		if (!row_end) begin
			if (c > 0)
				below_err[c - 1] = fsd_pkg::err_t'(clip(longint'(pend_below_left)
					+ weigh(err, fsd_pkg::W_BELOW_LEFT)));
			pend_below_left  = fsd_pkg::err_t'(clip(longint'(part_below_right)
				+ weigh(err, fsd_pkg::W_BELOW)));
			part_below_right = col_end ? fsd_pkg::err_t'(0)
				: fsd_pkg::err_t'(weigh(err, fsd_pkg::W_BELOW_RIGHT));
			// at row end the pending below sum has no left neighbor coming: flush it
			below_err[c]     = col_end ? pend_below_left : fsd_pkg::err_t'(0);
		end else begin
			below_err[c]     = '0;
			pend_below_left  = '0;
			part_below_right = '0;
		end
		word.last = col_end && row_end;

		if (col_end) begin
			col_pos          = 0;
			carry_right      = '0;
			pend_below_left  = '0;
			part_below_right = '0;
			if (row_end) begin
				row_pos = 0;
				foreach (below_err[i]) below_err[i] = '0;
			end else begin
				row_pos = r + 1;
			end
		end else begin
			col_pos = c + 1;
			row_pos = r;
		end
		halftone_q.push_back(word);
		accepted++;
	endfunction

	function void match_result(fsd_pkg::pix_t pixel, logic last);
		fsd_pkg::res_t want;
		if (halftone_q.size() == 0) begin
			$display("%0t: word with nothing expected: expected none, actual pixel %0d last %0b",
				$time, pixel, last);
			mismatches++;
			return;
		end
		want = halftone_q.pop_front();
		checked++;
		if (last) frames++;
		if (pixel !== want.pixel) begin
			$display("%0t: dithered_pixel mismatch on word %0d: expected %0d, actual %0d",
				$time, checked, want.pixel, pixel);
			mismatches++;
		end
		if (last !== want.last) begin
			$display("%0t: frame_last mismatch on word %0d: expected %0b, actual %0b",
				$time, checked, want.last, last);
			mismatches++;
		end
	endfunction
endclass

module floyd_steinberg_dither_tb;

	localparam int CYCLE_LIMIT = 100000;
	localparam int TARGET_ITEMS = 530;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_we;
	logic [fsd_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic [fsd_pkg::CFG_W-1:0]     cfg_data;
	bit                            no_gaps;
	int                            cycles;
	int                            phases;

	fsd_gray_if   gray_ch();
	fsd_dither_if dither_ch();

	halftone_scoreboard_t board = new();

	floyd_steinberg_dither dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.gray_ch   (gray_ch),
		.dither_ch (dither_ch)
	);

	always #5 clk = ~clk;

	function automatic bit take_break();
		return !no_gaps && ($urandom_range(0, 99) < 28);
	endfunction

	always @(negedge clk) dither_ch.ready <= !take_break();

	always @(posedge clk) begin
		if (arst_n && dither_ch.valid && dither_ch.ready)
			board.match_result(dither_ch.dithered_pixel, dither_ch.frame_last);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d words still expected", $time, board.pending());
			$display("floyd_steinberg_dither_tb: errors");
			$finish;
		end
	end

	// Enter and leave at a falling edge; valid stays high for a following word.
	task automatic send_pixel(input fsd_pkg::pix_t p);
		while (take_break()) begin
			gray_ch.valid <= 1'b0;
			@(negedge clk);
		end
		gray_ch.valid      <= 1'b1;
		gray_ch.gray_pixel <= p;
		@(posedge clk);
		while (!gray_ch.ready) @(posedge clk);
		board.take_pixel(p);
		@(negedge clk);
	endtask

	// Drop valid and let every expected word drain before touching the sizes.
	task automatic wait_idle();
		gray_ch.valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_frame(input logic [fsd_pkg::CFG_W-1:0] w,
			input logic [fsd_pkg::CFG_W-1:0] h);
		cfg_we   <= 1'b1;
		cfg_idx  <= fsd_pkg::REG_IMAGE_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		board.set_register(fsd_pkg::REG_IMAGE_WIDTH, w);
		@(negedge clk);
		cfg_idx  <= fsd_pkg::REG_IMAGE_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		board.set_register(fsd_pkg::REG_IMAGE_HEIGHT, h);
		@(negedge clk);
		cfg_we <= 1'b0;
		phases++;
	endtask

	function automatic fsd_pkg::pix_t draw_pixel(tone_t tone, fsd_pkg::pix_t flat_level);
		fsd_pkg::pix_t p;
		case (tone)
			TONE_MID: begin
				p = fsd_pkg::pix_t'($urandom_range(112, 143));
			end
			TONE_EXTREME: begin
				case ($urandom_range(0, 3))
					0: p = '0;
					1: p = fsd_pkg::PIX_MAX;
					2: p = 8'd1;
					default: p = 8'd254;
				endcase
			end
			TONE_FLAT: begin
				p = flat_level;
			end
			default: begin
				p = fsd_pkg::pix_t'($urandom_range(0, 255));
			end
		endcase
		return p;
	endfunction

	task automatic run_phase(input logic [fsd_pkg::CFG_W-1:0] w,
			input logic [fsd_pkg::CFG_W-1:0] h, input int count, input tone_t tone);
		fsd_pkg::pix_t flat_level;
		flat_level = fsd_pkg::pix_t'($urandom_range(0, 255));
		wait_idle();
		set_frame(w, h);
		repeat (count) send_pixel(draw_pixel(tone, flat_level));
	endtask

	initial begin
		fsd_pkg::pix_t             opening[12];
		logic [fsd_pkg::CFG_W-1:0] w, h;

		opening            = '{8'd0, 8'd255, 8'd127, 8'd128, 8'd126, 8'd129,
			8'd1, 8'd254, 8'd0, 8'd0, 8'd255, 8'd255};
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_idx            = fsd_pkg::REG_IMAGE_WIDTH;
		cfg_data           = '0;
		gray_ch.valid      = 1'b0;
		gray_ch.gray_pixel = '0;
		no_gaps            = 1'b0;
		phases             = 0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset sizes, threshold neighborhood and full-scale values
		foreach (opening[i]) send_pixel(opening[i]);
		// shrink mid-frame: column count now lies past the new last column
		wait_idle();
		set_frame(11'd2, 11'd2);
		send_pixel(8'd200);
		send_pixel(8'd60);
		send_pixel(8'd128);
		send_pixel(8'd127);
		// one-pixel frames: every word closes a frame
		wait_idle();
		set_frame(11'd1, 11'd1);
		send_pixel(8'd255);
		send_pixel(8'd0);
		send_pixel(8'd128);
		// zero sizes clamp to one
		wait_idle();
		set_frame(11'd0, 11'd0);
		send_pixel(8'd127);
		send_pixel(8'd255);
		// oversize clamps to the maximum
		wait_idle();
		set_frame(11'h7FF, 11'h7FF);
		send_pixel(8'd90);
		send_pixel(8'd170);
		send_pixel(8'd0);
		send_pixel(8'd255);

		run_phase(11'd4, 11'd3, 60, TONE_UNIFORM);
		run_phase(11'd1, 11'd6, 30, TONE_MID);
		run_phase(11'd9, 11'd1, 30, TONE_EXTREME);
		no_gaps = 1'b1;
		run_phase(11'd6, 11'd5, 120, TONE_UNIFORM);
		no_gaps = 1'b0;
		run_phase(11'd1024, 11'd2, 40, TONE_MID);
		run_phase(11'd2, 11'd1024, 40, TONE_FLAT);

		while (board.accepted < TARGET_ITEMS) begin
			if ($urandom_range(0, 5) == 0) begin
				case ($urandom_range(0, 3))
					0: w = 11'd0;
					1: w = 11'd1;
					2: w = 11'd1024;
					default: w = 11'h7FF;
				endcase
			end else begin
				w = fsd_pkg::CFG_W'($urandom_range(1, 12));
			end
			if ($urandom_range(0, 4) == 0) begin
				case ($urandom_range(0, 2))
					0: h = 11'd0;
					1: h = 11'd1;
					default: h = 11'h7FF;
				endcase
			end else begin
				h = fsd_pkg::CFG_W'($urandom_range(1, 6));
			end
			run_phase(w, h, $urandom_range(10, 50), tone_t'($urandom_range(0, 3)));
		end

		wait_idle();
		repeat (8) @(posedge clk);
		$display("summary: %0d pixels over %0d size settings, %0d words checked, %0d frames closed",
			board.accepted, phases, board.checked, board.frames);
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("floyd_steinberg_dither_tb: clean");
		end else begin
			$display("floyd_steinberg_dither_tb: errors");
		end
		$finish;
	end

endmodule
